### hw/rtl/ila_pkg.sv
package ila_pkg;

  // payload field widths
  localparam int REQ_W    = 16;
  localparam int ADDR_W   = 15;
  localparam int STATUS_W = 2;
  localparam int POLICY_W = 2;

  // fit policies
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

endpackage

### hw/rtl/ila_if.sv
interface ila_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [ila_pkg::REQ_W-1:0]  request_bytes;
  logic [ila_pkg::ADDR_W-1:0] payload_address;
  modport source (output valid, action, request_bytes, payload_address, input ready);
  modport sink (input valid, action, request_bytes, payload_address, output ready);
endinterface

interface ila_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ila_pkg::ADDR_W-1:0]   granted_address;
  logic [ila_pkg::STATUS_W-1:0] status;
  modport source (output valid, granted_address, status, input ready);
  modport sink (input valid, granted_address, status, output ready);
endinterface

### hw/rtl/ila_ram.sv
module ila_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/implicit_list_heap_allocator.sv
// free reads the freed block's header, then, below the heap end, the next one, merged
//   in if free; allocate reads headers in turn (S_RD, S_EV), after S_LG for next fit,
//   then grants via S_ALLOC and S_GRANT or grows the heap (one shared ram read port)
// throughput: one word at a time; the next request is taken once the result is taken
// reset: synchronous; control state clears at once, then a sweep clears all
//   HEAP_BYTES/WORD_BYTES block start marks, with no request taken meanwhile
module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES   = 32768,
  parameter int WORD_BYTES   = 8,
  parameter int HEADER_BYTES = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fit_policy_we,
  input  logic [ila_pkg::POLICY_W-1:0]   fit_policy_wdata,
  ila_req_if.sink                        req,
  ila_rsp_if.source                      rsp
);

  // offsets hold 0..HEAP_BYTES inclusive
  localparam int OW    = $clog2(HEAP_BYTES) + 1;
  localparam int WB    = $clog2(WORD_BYTES);
  localparam int DEPTH = HEAP_BYTES / WORD_BYTES;
  localparam int IW    = $clog2(DEPTH);
  localparam int HW    = OW + 1;
  // arithmetic width covers offsets and a rounded request
  localparam int AW    = ((OW > ila_pkg::REQ_W + 1) ? OW : ila_pkg::REQ_W + 1) + 1;
  localparam int SW    = IW + 2;
  localparam int GW    = ila_pkg::ADDR_W;

  localparam logic [AW-1:0] HDR   = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] WMASK = AW'(WORD_BYTES - 1);
  localparam logic [AW-1:0] HEAP  = AW'(HEAP_BYTES);
  localparam logic [SW-1:0] STEPS_MAX = SW'(DEPTH);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_LG    = 4'd3;
  localparam logic [3:0] S_EV    = 4'd4;
  localparam logic [3:0] S_ALLOC = 4'd5;
  localparam logic [3:0] S_GRANT = 4'd6;
  localparam logic [3:0] S_GROW  = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_FNXT  = 4'd9;

  // control state
  logic [3:0]                     state;
  logic [3:0]                     rd_ret;      // state that consumes the pending read
  logic [ila_pkg::POLICY_W-1:0]   policy;
  logic [OW-1:0]                  heap_end;
  logic [OW-1:0]                  last_block_start;
  logic [OW-1:0]                  last_granted;
  logic                           last_granted_valid;
  logic                           have;
  logic [SW-1:0]                  steps;
  logic [IW-1:0]                  clr;
  logic                           ovalid;

  // working registers
  logic [AW-1:0]                  size;        // rounded request
  logic [OW-1:0]                  rd_ptr;      // block whose header is being read
  logic [OW-1:0]                  start;       // next fit wrap point
  logic [OW-1:0]                  cur;         // block being freed
  logic [OW-1:0]                  cur_sz;
  logic [OW-1:0]                  pick;        // chosen free block
  logic [OW-1:0]                  pick_sz;
  logic [GW-1:0]                  ogrant;
  logic [ila_pkg::STATUS_W-1:0]   ostat;

  // header and mark stores
  logic           hdr_we, mark_we, mark_wdata, mark_q;
  logic [IW-1:0]  hdr_waddr, mark_waddr, raddr;
  logic [HW-1:0]  hdr_wdata, hdr_q;
  logic [OW-1:0]  hsz;
  logic           hused;

  assign hsz   = hdr_q[HW-1:1];
  assign hused = hdr_q[0];

  ila_ram #(.W(HW), .D(DEPTH)) u_hdr (
    .clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(hdr_wdata),
    .raddr(raddr), .rdata(hdr_q)
  );

  ila_ram #(.W(1), .D(DEPTH)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(raddr), .rdata(mark_q)
  );

  // shared datapath terms
  logic [AW-1:0] req_size;     // request rounded up to a word
  logic [AW-1:0] fa, fb;       // free address and its block start
  logic          free_bad;
  logic [AW-1:0] nxt;          // block following rd_ptr
  logic [AW-1:0] wrap;         // next fit successor with wraparound
  logic [SW-1:0] steps_inc;
  logic          fit, better, split;
  logic [AW-1:0] nb;           // remainder block of a split
  logic          room;

  assign req_size  = (AW'(req.request_bytes) + WMASK) & ~WMASK;
  assign fa        = AW'(req.payload_address);
  assign fb        = fa - HDR;
  assign free_bad  = (fa < HDR) || ((fb & WMASK) != '0) || (fb >= AW'(heap_end));
  assign nxt       = AW'(rd_ptr) + HDR + AW'(hsz);
  assign wrap      = (nxt < AW'(heap_end)) ? nxt : '0;
  assign steps_inc = steps + SW'(1);
  assign fit       = !hused && (AW'(hsz) >= size);
  assign better    = !have
                  || ((policy == ila_pkg::POL_BEST) && (hsz < pick_sz))
                  || ((policy == ila_pkg::POL_WORST) && (hsz > pick_sz));
  assign split     = AW'(pick_sz) >= HDR + AW'(WORD_BYTES) + size;
  assign nb        = AW'(pick) + HDR + size;
  assign room      = (HEAP - AW'(heap_end)) >= HDR + size;

  assign req.ready = (state == S_IDLE) && !ovalid;
  assign rsp.valid = ovalid;
  assign rsp.granted_address = ogrant;
  assign rsp.status = ostat;

  // read port: free lookup straight from the request, otherwise rd_ptr
  always_comb begin
    if (state == S_IDLE) begin
      raddr = fb[WB +: IW];
    end else begin
      raddr = rd_ptr[WB +: IW];
    end
  end

  // write ports
  always_comb begin
    hdr_we     = 1'b0;
    hdr_waddr  = pick[WB +: IW];
    hdr_wdata  = {pick_sz, 1'b1};
    mark_we    = 1'b0;
    mark_waddr = pick[WB +: IW];
    mark_wdata = 1'b1;
    case (state)
      S_CLR: begin
        mark_we    = 1'b1;
        mark_waddr = clr;
        mark_wdata = 1'b0;
      end
      S_ALLOC: begin
        if (split) begin
          hdr_we     = 1'b1;
          hdr_waddr  = nb[WB +: IW];
          hdr_wdata  = {OW'(AW'(pick_sz) - size - HDR), 1'b0};
          mark_we    = 1'b1;
          mark_waddr = nb[WB +: IW];
        end
      end
      S_GRANT: begin
        hdr_we  = 1'b1;
        mark_we = 1'b1;
      end
      S_GROW: begin
        hdr_we     = room;
        hdr_waddr  = heap_end[WB +: IW];
        hdr_wdata  = {OW'(size), 1'b1};
        mark_we    = room;
        mark_waddr = heap_end[WB +: IW];
      end
      S_FCHK: begin
        hdr_we    = mark_q && hused;
        hdr_waddr = cur[WB +: IW];
        hdr_wdata = {hsz, 1'b0};
      end
      S_FNXT: begin
        // absorb the following block if it is free
        hdr_we     = !hused;
        hdr_waddr  = cur[WB +: IW];
        hdr_wdata  = {OW'(AW'(cur_sz) + AW'(hsz) + HDR), 1'b0};
        mark_we    = !hused;
        mark_waddr = rd_ptr[WB +: IW];
        mark_wdata = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_CLR;
      rd_ret             <= S_IDLE;
      policy             <= ila_pkg::POL_FIRST;
      heap_end           <= '0;
      last_block_start   <= '0;
      last_granted       <= '0;
      last_granted_valid <= 1'b0;
      have               <= 1'b0;
      steps              <= '0;
      clr                <= '0;
      ovalid             <= 1'b0;
    end else begin
      if (fit_policy_we) begin
        policy <= fit_policy_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr <= clr + IW'(1);
          if (clr == IW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            size <= req_size;
            have <= 1'b0;
            if (req.action == ila_pkg::ACT_FREE) begin
              cur <= OW'(fb);
              if (free_bad) begin
                ovalid <= 1'b1;
                ogrant <= '0;
                ostat  <= ila_pkg::ST_BADFREE;
              end else begin
                // header read was issued this cycle
                state <= S_FCHK;
              end
            end else if (heap_end == '0) begin
              state <= S_GROW;
            end else if (policy == ila_pkg::POL_NEXT) begin
              if (!last_granted_valid) begin
                state <= S_GROW;
              end else begin
                rd_ptr <= last_granted;
                rd_ret <= S_LG;
                state  <= S_RD;
              end
            end else begin
              rd_ptr <= '0;
              rd_ret <= S_EV;
              state  <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= rd_ret;
        end
        S_LG: begin
          // next fit starts after the last grant, wrapping to the heap start
          rd_ptr <= OW'(wrap);
          start  <= OW'(wrap);
          steps  <= '0;
          rd_ret <= S_EV;
          state  <= S_RD;
        end
        S_EV: begin
          if (policy == ila_pkg::POL_NEXT) begin
            if (fit) begin
              pick    <= rd_ptr;
              pick_sz <= hsz;
              state   <= S_ALLOC;
            end else begin
              steps <= steps_inc;
              if ((OW'(wrap) == start) || (steps_inc > STEPS_MAX)) begin
                state <= S_GROW;
              end else begin
                rd_ptr <= OW'(wrap);
                state  <= S_RD;
              end
            end
          end else if ((policy == ila_pkg::POL_FIRST) && fit) begin
            pick    <= rd_ptr;
            pick_sz <= hsz;
            state   <= S_ALLOC;
          end else begin
            if (fit && better) begin
              pick    <= rd_ptr;
              pick_sz <= hsz;
              have    <= 1'b1;
            end
            if (nxt < AW'(heap_end)) begin
              rd_ptr <= OW'(nxt);
              state  <= S_RD;
            end else if (have || fit) begin
              state <= S_ALLOC;
            end else begin
              state <= S_GROW;
            end
          end
        end
        S_ALLOC: begin
          if (split) begin
            pick_sz <= OW'(size);
            if (last_block_start == pick) begin
              last_block_start <= OW'(nb);
            end
          end
          state <= S_GRANT;
        end
        S_GRANT: begin
          last_granted       <= pick;
          last_granted_valid <= 1'b1;
          ovalid             <= 1'b1;
          ogrant             <= GW'(AW'(pick) + HDR);
          ostat              <= ila_pkg::ST_OK;
          state              <= S_IDLE;
        end
        S_GROW: begin
          ovalid <= 1'b1;
          state  <= S_IDLE;
          if (room) begin
            heap_end           <= OW'(AW'(heap_end) + HDR + size);
            last_block_start   <= heap_end;
            last_granted       <= heap_end;
            last_granted_valid <= 1'b1;
            ogrant             <= GW'(AW'(heap_end) + HDR);
            ostat              <= ila_pkg::ST_OK;
          end else begin
            ogrant <= '0;
            ostat  <= ila_pkg::ST_FULL;
          end
        end
        S_FCHK: begin
          if (!mark_q || !hused) begin
            ovalid <= 1'b1;
            ogrant <= '0;
            ostat  <= ila_pkg::ST_BADFREE;
            state  <= S_IDLE;
          end else begin
            cur_sz <= hsz;
            if ((AW'(cur) + HDR + AW'(hsz)) < AW'(heap_end)) begin
              rd_ptr <= OW'(AW'(cur) + HDR + AW'(hsz));
              rd_ret <= S_FNXT;
              state  <= S_RD;
            end else begin
              ovalid <= 1'b1;
              ogrant <= '0;
              ostat  <= ila_pkg::ST_OK;
              state  <= S_IDLE;
            end
          end
        end
        S_FNXT: begin
          if (!hused) begin
            if (last_granted == rd_ptr) begin
              last_granted <= cur;
            end
            if (last_block_start == rd_ptr) begin
              last_block_start <= cur;
            end
          end
          ovalid <= 1'b1;
          ogrant <= '0;
          ostat  <= ila_pkg::ST_OK;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // one request in flight: an accepted word closes the input until its result is out
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another was in flight");

  // the heap end never passes the heap size
  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    AW'(heap_end) <= HEAP)
    else $error("heap end beyond heap size");

  // the last block always lies below the heap end once the heap holds a block
  a_last_block: assert property (@(posedge clk) disable iff (rst)
    (heap_end != '0) |-> (last_block_start < heap_end))
    else $error("last block start outside the heap");

  // a grant only ever comes with an ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.granted_address != '0)) |-> (rsp.status == ila_pkg::ST_OK))
    else $error("address granted with a failure status");
`endif

endmodule
